/* rtl/core/min_image_pair_distance_unit_macros.svh */
// Assertion macros for the minimum-image pair distance unit.
// Used by the checker module only; depends on nothing else.
`ifndef MIN_IMAGE_PAIR_DISTANCE_UNIT_MACROS_SVH
`define MIN_IMAGE_PAIR_DISTANCE_UNIT_MACROS_SVH

// Overlapping implication, switched off while reset is asserted.
`define MIPD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error(msg);

// Next-cycle implication that is also checked during reset.
`define MIPD_ASSERT_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/mipd_pkg.sv */
// Shared constants, widths and types of the minimum-image pair distance unit.
// Depends on nothing; every other file of the block but the macro header uses it.
`timescale 1ns / 1ps

package mipd_pkg;

  // Coordinate format and axis count.
  localparam int COORD_BITS = 24;
  localparam int MAX_AXES   = 3;
  localparam int NUM_AXES   = 3;

  // Register and result widths.
  localparam int BOX_W     = 23;
  localparam int CFG_W     = 23;
  localparam int CFG_IDX_W = 3;
  localparam int DIMS_W    = 2;
  localparam int DIST_W    = 25;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // Datapath widths derived from the coordinate format.
  localparam int MAG_W   = (COORD_BITS > BOX_W) ? COORD_BITS : BOX_W;
  localparam int SQ_W    = 2 * COORD_BITS;
  localparam int SUM_W   = SQ_W + $clog2(MAX_AXES);
  localparam int SUM_X_W = SUM_W + 1;
  localparam int SUMC_W  = (SUM_W > 64) ? 64 : SUM_W;
  localparam int RAD_W   = SUMC_W + (SUMC_W % 2);
  localparam int ROOT_W  = RAD_W / 2;
  localparam int REM_W   = ROOT_W + 3;
  localparam int ROOT_X_W = (ROOT_W > DIST_W) ? ROOT_W : DIST_W;

  // Pipeline depth: three axis stages, the sum, one stage per root bit, output.
  localparam int AXIS_LAT = 3;
  localparam int LATENCY  = AXIS_LAT + 1 + ROOT_W + 1;

  // Register reset values.
  localparam logic                 PERIODIC_RST = 1'b1;
  localparam logic [DIMS_W-1:0]    DIMS_RST     = 2'd3;
  localparam logic [BOX_W-1:0]     BOX_RST      = 23'd4194304;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIODIC = 3'd0,
    REG_DIMS     = 3'd1,
    REG_BOX_X    = 3'd2,
    REG_BOX_Y    = 3'd3,
    REG_BOX_Z    = 3'd4
  } cfg_reg_e_t;

  // Per-axis control carried from the register file to an axis lane.
  typedef struct packed {
    logic             periodic;
    logic             enable;
    logic [BOX_W-1:0] box;
  } axis_cfg_t;

endpackage

/* rtl/core/min_image_pair_distance_unit.sv */
// Top level of the minimum-image pair distance unit: registers, axis lanes,
// saturating sum, square root and output. Depends on mipd_pkg, mipd_axis, mipd_sqrt.
`timescale 1ns / 1ps

// Usage
// The input channel takes one pair of particle positions per transaction: a
// transaction is accepted at a rising edge where start is high and busy is
// low. busy is never raised, so a new pair may be presented in every cycle.
// Each pair gives one result transaction: out_pair_distance is valid for the
// single cycle in which out_strobe is high; the receiver cannot stall, so
// results simply stream out in the order the pairs went in.
// A pair passes through the axis lane registers, the sum register, the square
// root pipeline (25 root bits) and the output register. Throughput is one
// pair per cycle, set by the fully pipelined square root.
// The register port writes periodic_mode, dims_used and the three box
// lengths by index; writes take effect at once and should only be made while
// no pair is in flight. A synchronous reset restores the register defaults
// (periodic, three axes, box 1024.0) and clears every pipeline valid bit.

module min_image_pair_distance_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // Input channel
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [mipd_pkg::COORD_BITS-1:0] in_first_x,
  input  logic signed [mipd_pkg::COORD_BITS-1:0] in_first_y,
  input  logic signed [mipd_pkg::COORD_BITS-1:0] in_first_z,
  input  logic signed [mipd_pkg::COORD_BITS-1:0] in_second_x,
  input  logic signed [mipd_pkg::COORD_BITS-1:0] in_second_y,
  input  logic signed [mipd_pkg::COORD_BITS-1:0] in_second_z,
  // Result channel
  output logic                                   out_strobe,
  output logic        [mipd_pkg::DIST_W-1:0]     out_pair_distance,
  // Register write port
  input  logic                                   cfg_we,
  input  logic        [mipd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [mipd_pkg::CFG_W-1:0]      cfg_data
);

  localparam int NA = mipd_pkg::NUM_AXES;

  // Register file.
  logic                          periodic_r;
  logic [mipd_pkg::DIMS_W-1:0]   dims_r;
  logic [mipd_pkg::BOX_W-1:0]    box_r [NA];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      periodic_r <= mipd_pkg::PERIODIC_RST;
      dims_r     <= mipd_pkg::DIMS_RST;
      for (int i = 0; i < NA; i++) begin
        box_r[i] <= mipd_pkg::BOX_RST;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        mipd_pkg::REG_PERIODIC: periodic_r <= cfg_data[0];
        mipd_pkg::REG_DIMS:     dims_r     <= cfg_data[mipd_pkg::DIMS_W-1:0];
        mipd_pkg::REG_BOX_X:    box_r[0]   <= cfg_data[mipd_pkg::BOX_W-1:0];
        mipd_pkg::REG_BOX_Y:    box_r[1]   <= cfg_data[mipd_pkg::BOX_W-1:0];
        mipd_pkg::REG_BOX_Z:    box_r[2]   <= cfg_data[mipd_pkg::BOX_W-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline never holds off the sender.
  assign busy = 1'b0;

  logic signed [mipd_pkg::COORD_BITS-1:0] first_a  [NA];
  logic signed [mipd_pkg::COORD_BITS-1:0] second_a [NA];
  logic        [mipd_pkg::SQ_W-1:0]       sq_a     [NA];

  assign first_a[0]  = in_first_x;
  assign first_a[1]  = in_first_y;
  assign first_a[2]  = in_first_z;
  assign second_a[0] = in_second_x;
  assign second_a[1] = in_second_y;
  assign second_a[2] = in_second_z;

  // One lane per axis. An axis beyond dims_used, or beyond the supported
  // count, contributes a zero difference and therefore a zero square.
  for (genvar a = 0; a < NA; a++) begin : g_axis
    mipd_pkg::axis_cfg_t lane_cfg;

    assign lane_cfg.periodic = periodic_r;
    assign lane_cfg.enable   = (a < mipd_pkg::MAX_AXES) && (32'(dims_r) > a);
    assign lane_cfg.box      = box_r[a];

    mipd_axis u_axis (
      .clk      (clk),
      .first_c  (first_a[a]),
      .second_c (second_a[a]),
      .cfg      (lane_cfg),
      .sq       (sq_a[a])
    );
  end

  // Valid bits that run alongside the axis lanes.
  logic [mipd_pkg::AXIS_LAT-1:0] axis_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_valid_r <= '0;
    end else begin
      axis_valid_r <= {axis_valid_r[mipd_pkg::AXIS_LAT-2:0], start & ~busy};
    end
  end

  // Sum of squares, widened by one bit so that any overflow of the 50-bit
  // limit shows above it; an overflowing sum is pinned at all ones.
  logic [mipd_pkg::SUM_X_W-1:0] sum_x;
  logic                         sum_over;
  logic [mipd_pkg::SUMC_W-1:0]  sum_nxt, sum_r;
  logic                         sum_valid_r;

  always_comb begin
    sum_x = mipd_pkg::SUM_X_W'(sq_a[0]) + mipd_pkg::SUM_X_W'(sq_a[1])
          + mipd_pkg::SUM_X_W'(sq_a[2]);
    sum_over = |(sum_x >> mipd_pkg::SUMC_W);
    sum_nxt  = sum_over ? {mipd_pkg::SUMC_W{1'b1}} : sum_x[mipd_pkg::SUMC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_valid_r <= 1'b0;
    end else begin
      sum_valid_r <= axis_valid_r[mipd_pkg::AXIS_LAT-1];
    end
    sum_r <= sum_nxt;
  end

  // Floor square root.
  logic                         root_valid;
  logic [mipd_pkg::ROOT_W-1:0]  root;

  mipd_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sum_valid_r),
    .in_rad    (mipd_pkg::RAD_W'(sum_r)),
    .out_valid (root_valid),
    .out_root  (root)
  );

  // Output register, with the distance clamped to its field width.
  logic [mipd_pkg::ROOT_X_W-1:0] root_x;
  logic [mipd_pkg::DIST_W-1:0]   dist_nxt, dist_r;
  logic                          strobe_r;

  always_comb begin
    root_x   = mipd_pkg::ROOT_X_W'(root);
    dist_nxt = (root_x > mipd_pkg::ROOT_X_W'(mipd_pkg::DIST_MAX))
             ? mipd_pkg::DIST_MAX : root_x[mipd_pkg::DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= root_valid;
    end
    dist_r <= dist_nxt;
  end

  assign out_strobe        = strobe_r;
  assign out_pair_distance = dist_r;

endmodule

/* rtl/core/mipd_axis.sv */
// One axis lane: difference, minimum-image fold and square in three stages.
// Depends on mipd_pkg.
`timescale 1ns / 1ps

module mipd_axis (
  input  logic                                  clk,
  input  logic signed [mipd_pkg::COORD_BITS-1:0] first_c,
  input  logic signed [mipd_pkg::COORD_BITS-1:0] second_c,
  input  mipd_pkg::axis_cfg_t                   cfg,
  output logic        [mipd_pkg::SQ_W-1:0]       sq
);

  localparam int C    = mipd_pkg::COORD_BITS;
  localparam int M    = mipd_pkg::MAG_W;
  localparam int SQ_W = mipd_pkg::SQ_W;

  logic signed [C:0]   diff;
  logic        [C:0]   diff_abs;
  logic        [C-1:0] mag_nxt,  mag_r;
  logic        [M-1:0] mag_x, box_x, over, under;
  logic        [C-1:0] fold_nxt, fold_r;
  logic        [SQ_W-1:0] sq_nxt, sq_r;

  // Stage 1: absolute difference, forced to zero for an unused axis.
  always_comb begin
    diff     = {first_c[C-1], first_c} - {second_c[C-1], second_c};
    diff_abs = diff[C] ? (-diff) : diff;
    mag_nxt  = cfg.enable ? diff_abs[C-1:0] : '0;
  end

  // Stage 2: minimum-image fold. The chosen fold never exceeds the magnitude.
  always_comb begin
    mag_x    = M'(mag_r);
    box_x    = M'(cfg.box);
    over     = mag_x - box_x;
    under    = box_x - mag_x;
    fold_nxt = mag_r;
    if (cfg.periodic) begin
      if (mag_x > box_x) begin
        fold_nxt = over[C-1:0];
      end else if (under < mag_x) begin
        fold_nxt = under[C-1:0];
      end
    end
  end

  // Stage 3: square.
  assign sq_nxt = SQ_W'(fold_r) * SQ_W'(fold_r);

  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    fold_r <= fold_nxt;
    sq_r   <= sq_nxt;
  end

  assign sq = sq_r;

endmodule

/* rtl/core/mipd_sqrt.sv */
// Pipelined floor square root, one result bit resolved per register stage.
// Depends on mipd_pkg.
`timescale 1ns / 1ps

module mipd_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [mipd_pkg::RAD_W-1:0]    in_rad,
  output logic                          out_valid,
  output logic [mipd_pkg::ROOT_W-1:0]   out_root
);

  localparam int RW = mipd_pkg::RAD_W;
  localparam int QW = mipd_pkg::ROOT_W;
  localparam int EW = mipd_pkg::REM_W;

  logic          valid_r [QW];
  logic [QW-1:0] root_r  [QW];
  logic [EW-1:0] rem_r   [QW-1];
  logic [RW-1:0] rad_r   [QW-1];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic          src_valid;
    logic [QW-1:0] src_root;
    logic [EW-1:0] src_rem;
    logic [RW-1:0] src_rad;
    logic [EW-1:0] rem_sh, trial, rem_nxt;
    logic          ge;

    if (k == 0) begin : g_src_in
      assign src_valid = in_valid;
      assign src_root  = '0;
      assign src_rem   = '0;
      assign src_rad   = in_rad;
    end else begin : g_src_reg
      assign src_valid = valid_r[k-1];
      assign src_root  = root_r[k-1];
      assign src_rem   = rem_r[k-1];
      assign src_rad   = rad_r[k-1];
    end

    // Bring down the next two radicand bits and try the next root bit.
    always_comb begin
      rem_sh  = {src_rem[EW-3:0], src_rad[RW-1 -: 2]};
      trial   = {1'b0, src_root, 2'b01};
      ge      = (rem_sh >= trial);
      rem_nxt = ge ? (rem_sh - trial) : rem_sh;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else begin
        valid_r[k] <= src_valid;
      end
      root_r[k] <= {src_root[QW-2:0], ge};
    end

    if (k < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_r[k] <= rem_nxt;
        rad_r[k] <= {src_rad[RW-3:0], 2'b00};
      end
    end
  end

  assign out_valid = valid_r[QW-1];
  assign out_root  = root_r[QW-1];

endmodule

/* rtl/core/mipd_checker.sv */
// Port-level checks of the pair distance unit, bound to its top level.
// Depends on mipd_pkg and min_image_pair_distance_unit_macros.svh.
`timescale 1ns / 1ps
`include "min_image_pair_distance_unit_macros.svh"

module mipd_checker (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   start,
  input logic                                   busy,
  input logic signed [mipd_pkg::COORD_BITS-1:0] in_first_x,
  input logic signed [mipd_pkg::COORD_BITS-1:0] in_first_y,
  input logic signed [mipd_pkg::COORD_BITS-1:0] in_first_z,
  input logic signed [mipd_pkg::COORD_BITS-1:0] in_second_x,
  input logic signed [mipd_pkg::COORD_BITS-1:0] in_second_y,
  input logic signed [mipd_pkg::COORD_BITS-1:0] in_second_z,
  input logic                                   out_strobe,
  input logic        [mipd_pkg::DIST_W-1:0]     out_pair_distance
);

  localparam int LAT = mipd_pkg::LATENCY;

  logic accept;
  logic same_point;

  assign accept     = start && !busy;
  assign same_point = (in_first_x == in_second_x) && (in_first_y == in_second_y)
                   && (in_first_z == in_second_z);

  // Every accepted pair produces a result after the fixed latency.
  `MIPD_ASSERT_IMPL(a_result_follows, clk, rst_n, accept, ##LAT out_strobe, "pair gave no result")

  // No result appears without a pair accepted the latency before.
  `MIPD_ASSERT_IMPL(a_no_spurious, clk, rst_n, out_strobe, $past(accept, LAT), "result without a pair")

  // Coincident points are at distance zero whatever the registers hold.
  `MIPD_ASSERT_IMPL(a_zero_dist, clk, rst_n, accept && same_point, ##LAT (out_pair_distance == '0), "not zero")

  // Reset empties the pipeline.
  `MIPD_ASSERT_NEXT(a_reset_quiet, clk, !rst_n, !out_strobe, "result strobe after reset")

endmodule

bind min_image_pair_distance_unit mipd_checker u_mipd_checker (.*);

/* sim/testbench.sv */
// Self-checking testbench for min_image_pair_distance_unit: directed and random particle pairs
// over several register settings, each result checked against an in-bench distance predictor.
// Depends on mipd_pkg and the min_image_pair_distance_unit RTL.
`timescale 1ns / 1ps

module testbench;
  import mipd_pkg::*;

  // One pair of particle positions, axis 0 in the lowest slice. drain_first makes the driver
  // hold the pair back until every earlier result has come out of the pipeline.
  typedef struct packed {
    logic [NUM_AXES-1:0][COORD_BITS-1:0] first_pos;
    logic [NUM_AXES-1:0][COORD_BITS-1:0] second_pos;
    logic                                drain_first;
  } pair_t;

  localparam int NUM_PHASES      = 12;
  localparam int ITEMS_PER_PHASE = 104;
  localparam int REPORT_LIMIT    = 10;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                         start       = 1'b0;
  logic                         busy;
  logic signed [COORD_BITS-1:0] in_first_x  = '0;
  logic signed [COORD_BITS-1:0] in_first_y  = '0;
  logic signed [COORD_BITS-1:0] in_first_z  = '0;
  logic signed [COORD_BITS-1:0] in_second_x = '0;
  logic signed [COORD_BITS-1:0] in_second_y = '0;
  logic signed [COORD_BITS-1:0] in_second_z = '0;
  logic                         out_strobe;
  logic [DIST_W-1:0]            out_pair_distance;
  logic                         cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]         cfg_index   = '0;
  logic [CFG_W-1:0]             cfg_data    = '0;

  // The bench's own copy of the register file, updated as each write is issued.
  logic              periodic_copy = PERIODIC_RST;
  logic [DIMS_W-1:0] dims_copy     = DIMS_RST;
  logic [BOX_W-1:0]  box_copy [NUM_AXES] = '{BOX_RST, BOX_RST, BOX_RST};

  pair_t             pending_pairs [$];
  logic [DIST_W-1:0] expected_distances [$];
  pair_t             active_pair;
  int                gap_left    = 0;
  bit                no_idle     = 1'b0;
  int                fault_count = 0;

  always #5 clk = ~clk;

  min_image_pair_distance_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_first_x       (in_first_x),
    .in_first_y       (in_first_y),
    .in_first_z       (in_first_z),
    .in_second_x      (in_second_x),
    .in_second_y      (in_second_y),
    .in_second_z      (in_second_z),
    .out_strobe       (out_strobe),
    .out_pair_distance(out_pair_distance),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // Integer floor of the square root, found one result bit at a time from the top. The root
  // of a 64-bit value fits in 32 bits, so the trial square never overflows.
  function automatic longint unsigned floor_root(longint unsigned value);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= value) root = trial;
    end
    return root;
  endfunction

  // Expected distance for one pair under the register values currently held in the copy.
  function automatic logic [DIST_W-1:0] min_image_distance(pair_t p);
    longint          a;
    longint          b;
    longint          diff;
    longint unsigned d;
    longint unsigned box;
    longint unsigned sq;
    longint unsigned sum;
    longint unsigned root;
    int              axes;
    sum  = 0;
    axes = int'(dims_copy);
    if (axes > MAX_AXES) axes = MAX_AXES;
    for (int i = 0; i < axes; i++) begin
      a    = longint'($signed(p.first_pos[i]));
      b    = longint'($signed(p.second_pos[i]));
      diff = a - b;
      d    = (diff < 0) ? -diff : diff;
      if (periodic_copy) begin
        box = 64'(box_copy[i]);
        // A separation beyond the box folds back by one box length; otherwise the nearer
        // of the direct and the wrapped separation wins.
        if (d > box) begin
          d = d - box;
        end else if (box - d < d) begin
          d = box - d;
        end
      end
      sq = d * d;
      if (sum > 64'hFFFF_FFFF_FFFF_FFFF - sq) sum = 64'hFFFF_FFFF_FFFF_FFFF;
      else sum = sum + sq;
    end
    root = floor_root(sum);
    if (root > 64'(DIST_MAX)) root = 64'(DIST_MAX);
    return root[DIST_W-1:0];
  endfunction

  function automatic pair_t make_pair(int fx, int fy, int fz, int sx, int sy, int sz);
    pair_t p;
    p.first_pos[0]  = COORD_BITS'(fx);
    p.first_pos[1]  = COORD_BITS'(fy);
    p.first_pos[2]  = COORD_BITS'(fz);
    p.second_pos[0] = COORD_BITS'(sx);
    p.second_pos[1] = COORD_BITS'(sy);
    p.second_pos[2] = COORD_BITS'(sz);
    p.drain_first   = 1'b0;
    return p;
  endfunction

  // Random pair, shaped per axis so that separations near the box length, near half of it
  // and near zero turn up often, besides fully random and extreme coordinates.
  function automatic pair_t random_pair();
    pair_t p;
    int    offset;
    int    sel;
    for (int i = 0; i < NUM_AXES; i++) begin
      p.first_pos[i]  = COORD_BITS'($urandom);
      p.second_pos[i] = COORD_BITS'($urandom);
      sel = $urandom_range(0, 7);
      case (sel)
        3: begin
          case ($urandom_range(0, 3))
            0: p.first_pos[i] = {1'b1, {(COORD_BITS-1){1'b0}}};
            1: p.first_pos[i] = {1'b0, {(COORD_BITS-1){1'b1}}};
            2: p.first_pos[i] = '0;
            default: p.first_pos[i] = '1;
          endcase
          case ($urandom_range(0, 3))
            0: p.second_pos[i] = {1'b1, {(COORD_BITS-1){1'b0}}};
            1: p.second_pos[i] = {1'b0, {(COORD_BITS-1){1'b1}}};
            2: p.second_pos[i] = '0;
            default: p.second_pos[i] = '1;
          endcase
        end
        4, 5: begin
          offset = int'(box_copy[i]) + $urandom_range(0, 16) - 8;
          if ($urandom_range(0, 1)) offset = -offset;
          p.second_pos[i] = COORD_BITS'(int'(p.first_pos[i]) + offset);
        end
        6: begin
          offset = int'(box_copy[i] >> 1) + $urandom_range(0, 4) - 2;
          if ($urandom_range(0, 1)) offset = -offset;
          p.second_pos[i] = COORD_BITS'(int'(p.first_pos[i]) + offset);
        end
        7: p.second_pos[i] = COORD_BITS'(int'(p.first_pos[i]) + int'($urandom_range(0, 64)) - 32);
        default: ;
      endcase
    end
    p.drain_first = 1'b0;
    return p;
  endfunction

  // Driver: presents one pending pair per transaction with a random idle gap before each,
  // except in phases that run without idling. The expected distance is worked out at the
  // edge that accepts the transaction. start gets exactly one assignment per edge.
  always @(posedge clk) begin
    logic next_start;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      next_start = start;
      if (start && !busy) begin
        expected_distances.push_back(min_image_distance(active_pair));
        next_start = 1'b0;
      end
      if (!next_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_pairs.size() > 0 &&
                     (!pending_pairs[0].drain_first || expected_distances.size() == 0)) begin
          active_pair = pending_pairs.pop_front();
          in_first_x  <= active_pair.first_pos[0];
          in_first_y  <= active_pair.first_pos[1];
          in_first_z  <= active_pair.first_pos[2];
          in_second_x <= active_pair.second_pos[0];
          in_second_y <= active_pair.second_pos[1];
          in_second_z <= active_pair.second_pos[2];
          next_start  = 1'b1;
          gap_left    = no_idle ? 0 : int'($urandom_range(0, 3));
        end
      end
      start <= next_start;
    end
  end

  // Monitor: every strobed result is matched against the oldest outstanding expectation.
  always @(posedge clk) begin
    logic [DIST_W-1:0] want;
    if (rst_n && out_strobe) begin
      if (expected_distances.size() == 0) begin
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
          $display("unexpected result transaction: pair_distance=%0d", out_pair_distance);
      end else begin
        want = expected_distances.pop_front();
        if (out_pair_distance !== want) begin
          fault_count++;
          if (fault_count <= REPORT_LIMIT)
            $display("pair_distance mismatch: expected %0d, got %0d", want, out_pair_distance);
        end
      end
    end
  end

  // Waits until nothing is queued, nothing is on the input and every result has come out,
  // then lets the pipeline depth pass so that the block is certainly idle.
  task automatic wait_for_idle();
    while (pending_pairs.size() != 0 || start || expected_distances.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // One register write; the predictor's copy takes the same value, masked as the block does.
  task automatic write_reg(cfg_reg_e_t idx, logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_PERIODIC: periodic_copy = value[0];
      REG_DIMS:     dims_copy     = value[DIMS_W-1:0];
      REG_BOX_X:    box_copy[0]   = value[BOX_W-1:0];
      REG_BOX_Y:    box_copy[1]   = value[BOX_W-1:0];
      REG_BOX_Z:    box_copy[2]   = value[BOX_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [BOX_W-1:0] random_box();
    case ($urandom_range(0, 3))
      0:       return BOX_W'($urandom_range(0, 8192));
      1:       return BOX_W'($urandom_range(4096, 1 << 20));
      default: return BOX_W'($urandom);
    endcase
  endfunction

  initial begin
    logic             periodic_val;
    logic [DIMS_W-1:0] dims_val;
    logic [BOX_W-1:0] box_val [NUM_AXES];
    logic [CFG_W-1:0] upper_noise;
    int               drain_slot;
    pair_t            p;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed pairs under the reset settings: periodic, three axes, box 1024.0.
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(8388607, 8388607, 8388607,
                                      -8388608, -8388608, -8388608));
    pending_pairs.push_back(make_pair(-8388608, -8388608, -8388608,
                                      8388607, 8388607, 8388607));
    pending_pairs.push_back(make_pair(-8388608, 8388607, 0, -8388608, 8388607, 0));
    // Separation exactly one box: wraps to zero.
    pending_pairs.push_back(make_pair(0, 0, 0, 4194304, -4194304, 4194304));
    // Separation exactly half a box, just past half and just below it.
    pending_pairs.push_back(make_pair(0, 0, 0, 2097152, 2097152, -2097152));
    pending_pairs.push_back(make_pair(0, 0, 0, 2097153, -2097153, 2097153));
    pending_pairs.push_back(make_pair(0, 0, 0, 2097151, 2097151, 2097151));
    // Separation larger than the box: folds back by one box length.
    pending_pairs.push_back(make_pair(0, 0, 0, 4194305, -4194305, 6000000));
    pending_pairs.push_back(make_pair(-1, 1, 4096, 1, -1, -4096));
    pending_pairs.push_back(make_pair(100, -200, 300, 100, -200, 300));
    pending_pairs.push_back(make_pair(8388607, 0, -8388608, 0, 8388607, 0));
    p = make_pair(12345, -54321, 777, -4000000, 3000000, 99);
    p.drain_first = 1'b1;
    pending_pairs.push_back(p);
    pending_pairs.push_back(make_pair(-8388608, -8388608, -8388608, 0, 0, 0));

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      wait_for_idle();

      // Settings per phase: the first few cover the extremes, the rest are random.
      periodic_val = 1'($urandom_range(0, 1));
      dims_val     = DIMS_W'($urandom_range(1, 3));
      for (int i = 0; i < NUM_AXES; i++) box_val[i] = random_box();
      upper_noise = '0;
      case (phase)
        0: begin periodic_val = 1'b0; dims_val = 2'd3; end
        1: begin periodic_val = 1'b1; dims_val = 2'd1; box_val[0] = '1; end
        // No axes counted: every distance is zero.
        2: begin periodic_val = 1'b1; dims_val = 2'd0; end
        3: begin
          periodic_val = 1'b1;
          dims_val     = 2'd3;
          for (int i = 0; i < NUM_AXES; i++) box_val[i] = '0;
        end
        4: begin
          periodic_val = 1'b1;
          dims_val     = 2'd2;
          for (int i = 0; i < NUM_AXES; i++) box_val[i] = '1;
        end
        5: begin periodic_val = 1'b0; dims_val = 2'd1; end
        6: begin periodic_val = 1'b0; dims_val = 2'd2; end
        default: upper_noise = CFG_W'($urandom);
      endcase

      // Bits above each register's width are set at random in later phases; they must be
      // ignored by the block.
      write_reg(REG_PERIODIC, {upper_noise[CFG_W-1:1], periodic_val});
      write_reg(REG_DIMS, {upper_noise[CFG_W-1:DIMS_W], dims_val});
      write_reg(REG_BOX_X, box_val[0]);
      write_reg(REG_BOX_Y, box_val[1]);
      write_reg(REG_BOX_Z, box_val[2]);
      @(posedge clk);
      cfg_we <= 1'b0;

      no_idle    = (phase % 4 == 1);
      drain_slot = $urandom_range(10, ITEMS_PER_PHASE - 10);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        p = random_pair();
        p.drain_first = (n == drain_slot);
        pending_pairs.push_back(p);
      end
    end

    wait_for_idle();
    if (fault_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Guard against a hung pipeline: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/mipd_pkg.sv
rtl/core/mipd_axis.sv
rtl/core/mipd_sqrt.sv
rtl/core/min_image_pair_distance_unit.sv
rtl/core/mipd_checker.sv
sim/testbench.sv
